// File: design/arc_pkg.sv
// ----------------------------------------------------------------------------
// arc_pkg
// shared types and constants for the address range classifier
// ----------------------------------------------------------------------------
package arc_pkg;

  localparam int MAX_RANGES_DEF = 512;
  localparam int WALK_BACK_DEF  = 64;
  localparam int ADDR_W         = 32;
  localparam int RIDX_W         = 9;
  localparam int REQ_DEPTH      = 2;

  localparam logic FUNC_LOAD   = 1'b0;
  localparam logic FUNC_LOOKUP = 1'b1;

  typedef struct packed {
    logic              func;
    logic              first_range;
    logic [ADDR_W-1:0] range_start;
    logic [ADDR_W-1:0] range_end;
    logic [ADDR_W-1:0] probe_addr;
  } arc_req_t;

  typedef struct packed {
    logic              found;
    logic [RIDX_W-1:0] range_index;
    logic              dropped;
  } arc_rsp_t;

endpackage

// File: design/arc_ram.sv
// ----------------------------------------------------------------------------
// arc_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
module arc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: design/arc_req_queue.sv
// ----------------------------------------------------------------------------
// arc_req_queue
// front part: accepts requests and holds them until the engine takes them
// ----------------------------------------------------------------------------
module arc_req_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  output logic              full,
  input  arc_pkg::arc_req_t req,
  output logic              head_valid,
  output arc_pkg::arc_req_t head,
  input  logic              take
);
  import arc_pkg::*;

  localparam int PW = (REQ_DEPTH > 1) ? $clog2(REQ_DEPTH) : 1;
  localparam int CW = $clog2(REQ_DEPTH + 1);

  arc_req_t        slots [REQ_DEPTH];
  logic [PW-1:0]   wptr;
  logic [PW-1:0]   rptr;
  logic [CW-1:0]   count;
  logic            do_push;
  logic            do_pop;

  assign full       = (count == CW'(REQ_DEPTH));
  assign head_valid = (count != '0);
  assign head       = slots[rptr];
  assign do_push    = push && !full;
  assign do_pop     = take && head_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wptr <= (wptr == PW'(REQ_DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (do_pop) begin
        rptr <= (rptr == PW'(REQ_DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wptr] <= req;
    end
  end

endmodule

// File: design/arc_engine.sv
// ----------------------------------------------------------------------------
// arc_engine
// back part: sorted insert with shifting, binary search and walk back
// ----------------------------------------------------------------------------
module arc_engine #(
  parameter int MAX_RANGES = arc_pkg::MAX_RANGES_DEF,
  parameter int WALK_BACK  = arc_pkg::WALK_BACK_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              req_valid,
  input  arc_pkg::arc_req_t                 req,
  output logic                              req_take,
  output logic                              rsp_valid,
  output arc_pkg::arc_rsp_t                 rsp,
  input  logic                              rsp_ready,
  output logic [$clog2(MAX_RANGES+1)-1:0]   count
);
  import arc_pkg::*;

  localparam int AW = $clog2(MAX_RANGES);
  localparam int CW = $clog2(MAX_RANGES + 1);
  localparam int SW = $clog2(WALK_BACK);

  typedef struct packed {
    logic [ADDR_W-1:0] start_addr;
    logic [ADDR_W-1:0] end_addr;
    logic [AW-1:0]     load_idx;
  } ent_t;

  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_BS   = 9'b000000010,
    S_BSC  = 9'b000000100,
    S_SH   = 9'b000001000,
    S_SHW  = 9'b000010000,
    S_WK   = 9'b000100000,
    S_WKC  = 9'b001000000,
    S_DONE = 9'b010000000,
    S_HOLD = 9'b100000000
  } state_t;

  state_t            state, state_next;
  logic              is_load;
  logic [ADDR_W-1:0] key;
  logic [ADDR_W-1:0] ld_end;
  logic [CW-1:0]     lo;
  logic [CW-1:0]     hi;
  logic [CW-1:0]     ptr;
  logic [SW-1:0]     left;
  logic              have;
  logic [ADDR_W-1:0] best_w;
  logic [AW-1:0]     best_idx;
  logic [CW-1:0]     entry_count;
  arc_rsp_t          rsp_q;

  logic [CW:0]       mid_sum;
  logic [CW-1:0]     mid;
  logic [CW-1:0]     cnt0;
  logic              we;
  logic [AW-1:0]     waddr;
  ent_t              wdata;
  logic [AW-1:0]     raddr;
  ent_t              rdata;
  logic [ADDR_W-1:0] width_k;

  assign mid_sum   = {1'b0, lo} + {1'b0, hi};
  assign mid       = mid_sum[CW:1];
  assign cnt0      = req.first_range ? '0 : entry_count;
  assign width_k   = rdata.end_addr - rdata.start_addr;
  assign rsp_valid = (state == S_DONE);
  assign rsp       = rsp_q;
  assign req_take  = (state == S_IDLE) && req_valid;
  assign count     = entry_count;

  arc_ram #(
    .WIDTH($bits(ent_t)),
    .DEPTH(MAX_RANGES)
  ) u_table (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rdata)
  );

  always_comb begin
    state_next = state;
    we         = 1'b0;
    waddr      = ptr[AW-1:0];
    wdata      = rdata;
    raddr      = mid[AW-1:0];
    unique case (state)
      S_IDLE: begin
        if (req_valid) begin
          if (req.func == FUNC_LOAD && cnt0 == CW'(MAX_RANGES)) state_next = S_HOLD;
          else state_next = S_BS;
        end
      end
      S_BS: begin
        if (lo < hi) state_next = S_BSC;
        else if (is_load) state_next = S_SH;
        else state_next = S_WK;
      end
      S_BSC: state_next = S_BS;
      S_SH: begin
        raddr = ptr[AW-1:0] - 1'b1;
        if (ptr > lo) begin
          state_next = S_SHW;
        end else begin
          we         = 1'b1;
          waddr      = lo[AW-1:0];
          wdata      = '{start_addr: key, end_addr: ld_end, load_idx: entry_count[AW-1:0]};
          state_next = S_DONE;
        end
      end
      S_SHW: begin
        we         = 1'b1;
        state_next = S_SH;
      end
      S_WK: begin
        raddr = ptr[AW-1:0] - 1'b1;
        if (ptr != '0 && left != '0) state_next = S_WKC;
        else state_next = S_DONE;
      end
      S_WKC:  state_next = S_WK;
      S_DONE: if (rsp_ready) state_next = S_IDLE;
      S_HOLD: state_next = S_DONE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      entry_count <= '0;
    end else begin
      state <= state_next;
      if (state == S_IDLE && req_valid && req.func == FUNC_LOAD) begin
        entry_count <= cnt0;
      end
      if (state == S_SH && !(ptr > lo)) entry_count <= entry_count + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        is_load  <= (req.func == FUNC_LOAD);
        key      <= (req.func == FUNC_LOAD) ? req.range_start : req.probe_addr;
        ld_end   <= req.range_end;
        lo       <= '0;
        hi       <= (req.func == FUNC_LOAD) ? cnt0 : entry_count;
        have     <= 1'b0;
        best_idx <= '0;
        best_w   <= '0;
        rsp_q    <= '{found: 1'b0, range_index: '0, dropped: 1'b1};
      end
      S_BS: begin
        ptr  <= is_load ? entry_count : lo;
        left <= SW'(WALK_BACK - 1);
      end
      S_BSC: begin
        if (rdata.start_addr <= key) lo <= mid + 1'b1;
        else hi <= mid;
      end
      S_SH: rsp_q <= '0;
      S_SHW: ptr <= ptr - 1'b1;
      S_WK: begin
        if (ptr != '0 && left != '0) begin
          ptr  <= ptr - 1'b1;
          left <= left - 1'b1;
        end else begin
          rsp_q <= '{found: have, range_index: RIDX_W'(best_idx), dropped: 1'b0};
        end
      end
      S_WKC: begin
        if (key < rdata.end_addr && (!have || width_k < best_w)) begin
          have     <= 1'b1;
          best_w   <= width_k;
          best_idx <= rdata.load_idx;
        end
      end
      S_DONE, S_HOLD: ;
      default: ;
    endcase
  end

endmodule

// File: design/address_range_classifier_core.sv
// ----------------------------------------------------------------------------
// address_range_classifier_core
// sorted range table with narrowest-match lookup
// ----------------------------------------------------------------------------
// Requests enter a two-deep queue and are carried out one at a time by an
// engine built around a table ram with one write port, one read port and
// registered read. A lookup runs a binary search over the loaded ranges,
// then walks back over at most WALK_BACK-1 entries. A load runs the same
// search, then shifts every entry above the insert slot up by one to open
// it; a load that finds the table full is dropped. A finished result waits
// in an output register while the next request is accepted.
module address_range_classifier_core #(
  parameter int MAX_RANGES = arc_pkg::MAX_RANGES_DEF,
  parameter int WALK_BACK  = arc_pkg::WALK_BACK_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  output logic              full,
  input  arc_pkg::arc_req_t req,
  output logic              empty,
  input  logic              pop,
  output arc_pkg::arc_rsp_t rsp
);
  import arc_pkg::*;

  localparam int CW = $clog2(MAX_RANGES + 1);

  logic          head_valid;
  arc_req_t      head;
  logic          take;
  logic          eng_valid;
  arc_rsp_t      eng_rsp;
  logic          eng_ready;
  logic [CW-1:0] count;
  logic          out_valid;
  arc_rsp_t      out_q;

  arc_req_queue u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .req       (req),
    .head_valid(head_valid),
    .head      (head),
    .take      (take)
  );

  arc_engine #(
    .MAX_RANGES(MAX_RANGES),
    .WALK_BACK (WALK_BACK)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .req_valid(head_valid),
    .req      (head),
    .req_take (take),
    .rsp_valid(eng_valid),
    .rsp      (eng_rsp),
    .rsp_ready(eng_ready),
    .count    (count)
  );

  assign eng_ready = !out_valid || pop;
  assign empty     = !out_valid;
  assign rsp       = out_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (eng_valid && eng_ready) begin
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (eng_valid && eng_ready) out_q <= eng_rsp;
  end

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    eng_valid && out_valid && !pop |=> out_valid && $stable(out_q))
    else $error("result overwritten");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(MAX_RANGES))
    else $error("entry count over capacity");

  a_pop_drains: assert property (@(posedge clk) disable iff (rst)
    pop && !empty && !eng_valid |=> empty)
    else $error("result not released");

endmodule
